@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/ffra_pkg.sv @@
// Package for the first-fit region allocator: sizes, codes, payload types.
// Depends on nothing.
package ffra_pkg;
  localparam int unsigned DESCRIPTORS = 32;
  localparam int unsigned IDX_W = $clog2(DESCRIPTORS);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(DESCRIPTORS);
  localparam int unsigned OFF_W = 17;
  localparam int unsigned SIZE_W = 18;
  localparam logic [SIZE_W-1:0] POOL_UNITS = 18'h20000;
  localparam int unsigned CNT_W = 6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_ZERO_REF = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] request_size;
    logic [31:0]       owner_tag;
    logic [15:0]       region_type;
    logic [IDX_W-1:0]  region_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  granted_index;
    logic [OFF_W-1:0]  granted_offset;
    logic [SIZE_W-1:0] granted_size;
    logic [CNT_W-1:0]  live_regions;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture request, point cursor at descriptor 0
    OP_WALK_RD,   // cursor moves along next link
    OP_ALLOC,     // stamp region and split tail
    OP_REL,       // decrement refs, free, merge successor
    OP_MERGE_P,   // merge into predecessor
    OP_FAIL,
    OP_ZREF
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic fit;        // cursor region is free and large enough
    logic cur_valid;  // cursor is a live descriptor
    logic rel_bad;    // release target has zero refs
    logic rel_last;   // release drops final reference
    logic pred_free;  // predecessor exists and is free
  } sts_t;
endpackage

@@ rtl/core/ffra_datapath.sv @@
// Datapath of the allocator: descriptor table, spare list, list-edit ops.
// Depends on ffra_pkg.
module ffra_datapath (
  input  logic           clk,
  input  logic           rst,
  input  ffra_pkg::req_t in_req,
  input  ffra_pkg::cmd_t cmd,
  output ffra_pkg::sts_t sts,
  output ffra_pkg::rsp_t rsp
);
  localparam int unsigned N = ffra_pkg::DESCRIPTORS;
  localparam int unsigned IW = ffra_pkg::IDX_W;
  localparam int unsigned LW = ffra_pkg::LINK_W;

  logic [ffra_pkg::OFF_W-1:0]  offs  [N];
  logic [ffra_pkg::SIZE_W-1:0] sizes [N];
  logic [15:0]                 kinds [N];
  logic [15:0]                 refs  [N];
  logic [31:0]                 owners[N];
  logic [LW-1:0]               nxt   [N];
  logic [LW-1:0]               prv   [N];
  logic [LW-1:0]               spare_head;
  logic [ffra_pkg::CNT_W-1:0]  live_cnt;
  ffra_pkg::req_t              req;
  logic [LW-1:0]               cur;

  logic [IW-1:0]               ci, ri, pi, ni, ti, nni;
  logic [ffra_pkg::SIZE_W-1:0] rem;
  logic                        p_ok, n_ok, sp_ok;

  assign ci  = cur[IW-1:0];
  assign ri  = req.region_index[IW-1:0];
  assign rem = sizes[ci] - req.request_size;
  assign ti  = spare_head[IW-1:0];
  assign sp_ok = (spare_head < ffra_pkg::NIL_LINK);
  assign ni  = nxt[ri][IW-1:0];
  assign n_ok = (nxt[ri] < ffra_pkg::NIL_LINK) && (ni != ri) && (kinds[ni] == 16'd0);
  assign nni = nxt[ni][IW-1:0];
  assign pi  = prv[ri][IW-1:0];
  assign p_ok = (prv[ri] < ffra_pkg::NIL_LINK) && (pi != ri) && (kinds[pi] == 16'd0);

  assign sts.cur_valid = (cur < ffra_pkg::NIL_LINK);
  assign sts.fit = sts.cur_valid && (kinds[ci] == 16'd0) &&
                   (sizes[ci] >= req.request_size);
  assign sts.rel_bad = (refs[ri] == 16'd0);
  assign sts.rel_last = (refs[ri] == 16'd1);
  assign sts.pred_free = p_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        offs[i] <= '0;
        sizes[i] <= (i == 0) ? ffra_pkg::POOL_UNITS : '0;
        kinds[i] <= '0;
        refs[i] <= '0;
        owners[i] <= '0;
        prv[i] <= ffra_pkg::NIL_LINK;
        nxt[i] <= (i >= 1 && i + 1 < N) ? LW'(i + 1) : ffra_pkg::NIL_LINK;
      end
      spare_head <= LW'(1);
      live_cnt <= ffra_pkg::CNT_W'(1);
      cur <= '0;
    end else begin
      case (cmd.op)
        ffra_pkg::OP_LOAD: begin
          req <= in_req;
          cur <= '0;
        end
        ffra_pkg::OP_WALK_RD: begin
          cur <= nxt[ci];
        end
        ffra_pkg::OP_ALLOC: begin
          owners[ci] <= req.owner_tag;
          kinds[ci] <= req.region_type;
          refs[ci] <= 16'd1;
          rsp.status <= ffra_pkg::ST_OK;
          rsp.granted_index <= ci;
          rsp.granted_offset <= offs[ci];
          rsp.granted_size <= sizes[ci];
          rsp.live_regions <= live_cnt;
          if (sp_ok && rem != '0) begin
            spare_head <= nxt[ti];
            owners[ti] <= '0;
            kinds[ti] <= '0;
            refs[ti] <= '0;
            sizes[ti] <= rem;
            offs[ti] <= offs[ci] + req.request_size[ffra_pkg::OFF_W-1:0];
            prv[ti] <= cur;
            nxt[ti] <= nxt[ci];
            if (nxt[ci] < ffra_pkg::NIL_LINK) prv[nxt[ci][IW-1:0]] <= spare_head;
            nxt[ci] <= spare_head;
            sizes[ci] <= req.request_size;
            rsp.granted_size <= req.request_size;
            rsp.live_regions <= live_cnt + 1'b1;
            live_cnt <= live_cnt + 1'b1;
          end
        end
        ffra_pkg::OP_REL: begin
          refs[ri] <= refs[ri] - 16'd1;
          rsp.status <= ffra_pkg::ST_OK;
          rsp.granted_index <= req.region_index;
          rsp.granted_offset <= '0;
          rsp.granted_size <= '0;
          rsp.live_regions <= live_cnt;
          if (refs[ri] == 16'd1) begin
            kinds[ri] <= '0;
            if (n_ok) begin
              sizes[ri] <= sizes[ri] + sizes[ni];
              nxt[ri] <= nxt[ni];
              if (nxt[ni] < ffra_pkg::NIL_LINK) prv[nni] <= LW'(ri);
              nxt[ni] <= spare_head;
              prv[ni] <= ffra_pkg::NIL_LINK;
              refs[ni] <= '0;
              spare_head <= LW'(ni);
              live_cnt <= live_cnt - 1'b1;
              rsp.live_regions <= live_cnt - 1'b1;
            end
          end
        end
        ffra_pkg::OP_MERGE_P: begin
          sizes[pi] <= sizes[pi] + sizes[ri];
          nxt[pi] <= nxt[ri];
          if (nxt[ri] < ffra_pkg::NIL_LINK) prv[nxt[ri][IW-1:0]] <= prv[ri];
          nxt[ri] <= spare_head;
          prv[ri] <= ffra_pkg::NIL_LINK;
          refs[ri] <= '0;
          spare_head <= LW'(ri);
          live_cnt <= live_cnt - 1'b1;
          rsp.live_regions <= live_cnt - 1'b1;
        end
        ffra_pkg::OP_FAIL: begin
          rsp <= '{ffra_pkg::ST_NO_FIT, '0, '0, '0, live_cnt};
        end
        ffra_pkg::OP_ZREF: begin
          rsp <= '{ffra_pkg::ST_ZERO_REF, req.region_index, '0, '0, live_cnt};
        end
        default: begin
        end
      endcase
    end
  end
endmodule

@@ rtl/core/ffra_ctrl.sv @@
// Controller of the allocator: sequences walk, edit and result handoff.
// Depends on ffra_pkg.
module ffra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           mode,
  input  ffra_pkg::sts_t sts,
  output ffra_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {IDLE, WALK, REL, MERGE, DONE} state_t;
  state_t state;
  logic [ffra_pkg::LINK_W-1:0] steps;

  assign in_ready = (state == IDLE);
  assign out_valid = (state == DONE);

  always_comb begin
    cmd.op = ffra_pkg::OP_NONE;
    case (state)
      IDLE: if (in_valid) cmd.op = ffra_pkg::OP_LOAD;
      WALK: begin
        if (!sts.cur_valid || steps == ffra_pkg::NIL_LINK) cmd.op = ffra_pkg::OP_FAIL;
        else if (sts.fit) cmd.op = ffra_pkg::OP_ALLOC;
        else cmd.op = ffra_pkg::OP_WALK_RD;
      end
      REL: cmd.op = sts.rel_bad ? ffra_pkg::OP_ZREF : ffra_pkg::OP_REL;
      MERGE: if (sts.pred_free) cmd.op = ffra_pkg::OP_MERGE_P;
      default: cmd.op = ffra_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      steps <= '0;
    end else begin
      case (state)
        IDLE: if (in_valid) begin
          steps <= '0;
          state <= (mode == ffra_pkg::MODE_RELEASE) ? REL : WALK;
        end
        WALK: begin
          steps <= steps + 1'b1;
          if (cmd.op != ffra_pkg::OP_WALK_RD) state <= DONE;
        end
        REL: state <= (!sts.rel_bad && sts.rel_last) ? MERGE : DONE;
        MERGE: state <= DONE;
        DONE: if (out_ready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/first_fit_region_allocator.sv @@
// First-fit region allocator: 32 descriptors over a 131072-unit pool.
// Allocate: accept, walk from descriptor 0 to the first fit or the list end, result;
// release: accept, unref and merge successor, then predecessor if freed, result.
// One transaction at a time; the next is accepted in the cycle after the result is taken.
// Reset (rst, synchronous): one free region at descriptor 0, spares 1..31.
module first_fit_region_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffra_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ffra_pkg::rsp_t out_data
);
  ffra_pkg::cmd_t cmd;
  ffra_pkg::sts_t sts;

  // controller sequences; datapath holds the descriptor table and result register
  ffra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .mode(in_data.mode),
    .sts(sts), .cmd(cmd)
  );

  ffra_datapath u_dp (
    .clk(clk), .rst(rst), .in_req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule

@@ rtl/core/ffra_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
// Depends on ffra_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffra_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ffra_pkg::rsp_t out_data
);
  `ASSERT_IMPLIES(a_no_overlap, clk, rst, out_valid, !in_ready)
  `ASSERT_IMPLIES(a_status_code, clk, rst, out_valid, out_data.status != 2'd3)
  `ASSERT_IMPLIES(a_live_range, clk, rst, out_valid, out_data.live_regions != 6'd0)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind first_fit_region_allocator ffra_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ sim/tb_top.sv @@
// Testbench for the first-fit region allocator: directed and random allocate/release
// traffic checked against an in-bench model of the descriptor lists.
// Depends on ffra_pkg and first_fit_region_allocator.
`timescale 1ns / 100ps

module tb_top;
  localparam int NDESC = 32;
  localparam int NIL = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffra_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffra_pkg::rsp_t out_data;

  always #4 clk = ~clk;

  first_fit_region_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow copy of the allocator's descriptor state.
  logic [16:0] shadow_off [NDESC];
  logic [17:0] shadow_size [NDESC];
  logic [15:0] shadow_kind [NDESC];
  logic [15:0] shadow_refs [NDESC];
  logic [31:0] shadow_owner [NDESC];
  int shadow_next [NDESC];
  int shadow_prev [NDESC];
  int shadow_spare;
  int shadow_live;

  ffra_pkg::rsp_t pending_rsp[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit failed = 1'b0;
  int quiet_cycles = 0;

  task automatic shadow_reset();
    for (int i = 0; i < NDESC; i++) begin
      shadow_off[i] = '0;
      shadow_size[i] = '0;
      shadow_kind[i] = '0;
      shadow_refs[i] = '0;
      shadow_owner[i] = '0;
      shadow_prev[i] = NIL;
      shadow_next[i] = (i >= 1 && i + 1 < NDESC) ? i + 1 : NIL;
    end
    shadow_size[0] = ffra_pkg::POOL_UNITS;
    shadow_spare = 1;
    shadow_live = 1;
  endtask

  // Return a merged-away descriptor to the spare list.
  task automatic retire_desc(int d);
    shadow_next[d] = shadow_spare;
    shadow_prev[d] = NIL;
    shadow_refs[d] = '0;
    shadow_spare = d;
    if (shadow_live > 0) shadow_live--;
  endtask

  function automatic ffra_pkg::rsp_t pack_rsp(logic [1:0] st, int idx, logic [16:0] off,
                                              logic [17:0] sz);
    ffra_pkg::rsp_t r;
    r.status = st;
    r.granted_index = idx[4:0];
    r.granted_offset = off;
    r.granted_size = sz;
    r.live_regions = shadow_live[5:0];
    return r;
  endfunction

  // First-fit walk, stamp, optional tail split.
  task automatic predict_alloc(ffra_pkg::req_t q, output ffra_pkg::rsp_t r);
    int cur;
    int tail;
    bit found;
    logic [17:0] rem;
    cur = 0;
    found = 1'b0;
    for (int s = 0; s < NDESC; s++) begin
      if (cur >= NDESC) break;
      if (shadow_kind[cur] == 0 && shadow_size[cur] >= q.request_size) begin
        found = 1'b1;
        break;
      end
      cur = shadow_next[cur];
    end
    if (!found) begin
      r = pack_rsp(ffra_pkg::ST_NO_FIT, 0, '0, '0);
      return;
    end
    rem = shadow_size[cur] - q.request_size;
    shadow_owner[cur] = q.owner_tag;
    shadow_kind[cur] = q.region_type;
    shadow_refs[cur] = 16'd1;
    if (shadow_spare < NDESC && rem != 0) begin
      tail = shadow_spare;
      shadow_spare = shadow_next[tail];
      shadow_owner[tail] = '0;
      shadow_kind[tail] = '0;
      shadow_refs[tail] = '0;
      shadow_size[tail] = rem;
      shadow_off[tail] = shadow_off[cur] + 17'(q.request_size);
      shadow_prev[tail] = cur;
      shadow_next[tail] = shadow_next[cur];
      if (shadow_next[tail] < NDESC) shadow_prev[shadow_next[tail]] = tail;
      shadow_next[cur] = tail;
      shadow_size[cur] = q.request_size;
      shadow_live++;
    end
    r = pack_rsp(ffra_pkg::ST_OK, cur, shadow_off[cur], shadow_size[cur]);
  endtask

  // Drop a reference; on the last one free and coalesce both sides.
  task automatic predict_release(ffra_pkg::req_t q, output ffra_pkg::rsp_t r);
    int rr;
    int n;
    int p;
    rr = q.region_index;
    if (shadow_refs[rr] == 0) begin
      r = pack_rsp(ffra_pkg::ST_ZERO_REF, rr, '0, '0);
      return;
    end
    shadow_refs[rr]--;
    if (shadow_refs[rr] == 0) begin
      shadow_kind[rr] = '0;
      n = shadow_next[rr];
      if (n < NDESC && n != rr && shadow_kind[n] == 0) begin
        shadow_size[rr] += shadow_size[n];
        shadow_next[rr] = shadow_next[n];
        if (shadow_next[rr] < NDESC) shadow_prev[shadow_next[rr]] = rr;
        retire_desc(n);
      end
      p = shadow_prev[rr];
      if (p < NDESC && p != rr && shadow_kind[p] == 0) begin
        shadow_size[p] += shadow_size[rr];
        shadow_next[p] = shadow_next[rr];
        if (shadow_next[p] < NDESC) shadow_prev[shadow_next[p]] = p;
        retire_desc(rr);
      end
    end
    r = pack_rsp(ffra_pkg::ST_OK, rr, '0, '0);
  endtask

  // Send one transaction; predict at acceptance.
  task automatic send_req(ffra_pkg::req_t q);
    ffra_pkg::rsp_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (!in_ready);
    if (q.mode == ffra_pkg::MODE_ALLOC) predict_alloc(q, r);
    else predict_release(q, r);
    pending_rsp.push_back(r);
    in_valid <= 1'b0;
    @(posedge clk);                    // valid drops between back-to-back requests
  endtask

  task automatic send_alloc(logic [17:0] sz, logic [15:0] kind);
    ffra_pkg::req_t q;
    q.mode = ffra_pkg::MODE_ALLOC;
    q.request_size = sz;
    q.owner_tag = $urandom();
    q.region_type = kind;
    q.region_index = 5'($urandom());
    send_req(q);
  endtask

  task automatic send_release(int idx);
    ffra_pkg::req_t q;
    q.mode = ffra_pkg::MODE_RELEASE;
    q.request_size = 18'($urandom());
    q.owner_tag = $urandom();
    q.region_type = 16'($urandom());
    q.region_index = idx[4:0];
    send_req(q);
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall pattern on out_ready.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker, field by field against the oldest prediction.
  always @(posedge clk) begin
    ffra_pkg::rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        failed = 1'b1;
      end else begin
        e = pending_rsp.pop_front();
        if (out_data.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
        if (out_data.granted_index !== e.granted_index)
          $display("%0t: index expected %0d actual %0d", $time, e.granted_index,
                   out_data.granted_index);
        if (out_data.granted_offset !== e.granted_offset)
          $display("%0t: offset expected %0d actual %0d", $time, e.granted_offset,
                   out_data.granted_offset);
        if (out_data.granted_size !== e.granted_size)
          $display("%0t: size expected %0d actual %0d", $time, e.granted_size,
                   out_data.granted_size);
        if (out_data.live_regions !== e.live_regions)
          $display("%0t: live expected %0d actual %0d", $time, e.live_regions,
                   out_data.live_regions);
        if (out_data !== e) failed = 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Field extremes, zero and oversized requests, kind-zero stamps.
  task automatic test_directed();
    ffra_pkg::req_t q;
    send_alloc(18'h20000, 16'hFFFF);   // whole pool, no tail
    send_alloc(18'd1, 16'd1);          // nothing fits
    send_release(0);                   // frees pool
    send_release(0);                   // zero-reference release
    send_release(31);                  // spare descriptor
    send_alloc(18'h3FFFF, 16'd5);      // oversized
    send_alloc(18'd0, 16'd7);          // zero request, whole region split off
    send_alloc(18'd100, 16'd0);        // kind zero stays free
    send_alloc(18'd50, 16'd3);
    send_alloc(18'd1, 16'h8000);
    send_release(1);
    send_release(2);
    send_release(0);
    q = '1;
    q.mode = ffra_pkg::MODE_ALLOC;
    q.request_size = 18'd8;
    send_req(q);                       // all-ones owner and kind
    q = '0;
    q.mode = ffra_pkg::MODE_RELEASE;
    send_req(q);
    drain();
  endtask

  // Release every descriptor to coalesce back toward one region.
  task automatic test_sweep_release();
    for (int i = 0; i < NDESC; i++) send_release(i);
  endtask

  // Random traffic, half allocations and half releases (mostly of live regions), small sizes mostly.
  task automatic test_random(int count);
    int live_idx[$];
    int pick;
    logic [17:0] sz;
    for (int k = 0; k < count; k++) begin
      live_idx.delete();
      for (int i = 0; i < NDESC; i++) if (shadow_refs[i] != 0) live_idx.push_back(i);
      if ($urandom_range(99) < 50) begin
        case ($urandom_range(9))
          0: sz = 18'($urandom_range(18'h20000));
          1: sz = 18'($urandom());
          2: sz = 18'd0;
          default: sz = 18'($urandom_range(4096));
        endcase
        send_alloc(sz, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom()));
      end else if (live_idx.size() != 0 && $urandom_range(9) != 0) begin
        pick = live_idx[$urandom_range(live_idx.size() - 1)];
        send_release(pick);
      end else begin
        send_release($urandom_range(31));
      end
      if (k == count / 2) drain();     // sender holds off until all results are in
    end
  endtask

  initial begin
    shadow_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 77;
    test_directed();
    test_random(220);
    test_sweep_release();
    send_idle_pct = 77;
    recv_idle_pct = 17;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220);
    test_sweep_release();
    drain();
    repeat (50) @(posedge clk);
    if (!failed && pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ffra_pkg.sv
rtl/core/ffra_datapath.sv
rtl/core/ffra_ctrl.sv
rtl/core/first_fit_region_allocator.sv
rtl/core/ffra_checker.sv
sim/tb_top.sv
